[rtl/pip_pkg.sv]
`default_nettype none

package pip_pkg;

	localparam int MAX_VERTICES = 32;
	localparam int ADDR_W       = $clog2(MAX_VERTICES);
	localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
	localparam int COORD_W      = 24;
	localparam int DIFF_W       = COORD_W + 1;
	localparam int PROD_W       = 2 * DIFF_W;

	// item opcodes
	localparam logic [1:0] OP_CLEAR  = 2'd0;
	localparam logic [1:0] OP_APPEND = 2'd1;
	localparam logic [1:0] OP_TEST   = 2'd2;

	// result status codes
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_FEW  = 2'd2;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [DIFF_W-1:0]  diff_t;
	typedef logic signed [PROD_W-1:0]  prod_t;

	typedef struct packed {
		logic [1:0] op;
		coord_t     coord_x;
		coord_t     coord_y;
	} item_t;

	typedef struct packed {
		logic       inside_res;
		logic [1:0] status;
	} result_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
	} vertex_t;

	typedef struct packed {
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
	} vs_ctrl_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_FETCHJ,
		S_EDGE_A,
		S_EDGE_B,
		S_FINISH
	} state_t;

endpackage

`default_nettype wire

[rtl/pip_vstore.sv]
`default_nettype none

module pip_vstore
	import pip_pkg::*;
(
	input  wire logic     clk,
	input  wire vs_ctrl_t ctrl,
	input  wire vertex_t  wr_data,
	output vertex_t       rd_q
);

	vertex_t mem [MAX_VERTICES];

	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			mem[ctrl.wr_addr] <= wr_data;
		end
	end

	// hold read data until the next read
	always_ff @(posedge clk) begin
		if (ctrl.rd_en) begin
			rd_q <= mem[ctrl.rd_addr];
		end
	end

endmodule

`default_nettype wire

[rtl/pip_mul.sv]
`default_nettype none

module pip_mul
	import pip_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  en,
	input  wire diff_t a,
	input  wire diff_t b,
	output prod_t      prod_q
);

	prod_t prod_d;

	// sign-extend both operands to the full product width
	assign prod_d = prod_t'(a) * prod_t'(b);

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= prod_d;
		end
	end

endmodule

`default_nettype wire

[rtl/point_in_polygon_test.sv]
`default_nettype none

// Point-in-polygon test by crossing number on one stored polygon of up to
// MAX_VERTICES vertices (signed 24-bit millimetre coordinates). Each input
// transfer clears the polygon, appends a vertex or tests a point, and yields
// exactly one result transfer {inside_res, status}. Clear, append, unused
// opcodes and tests on a polygon with fewer than three vertices load the
// result register at the input transfer itself, so such items can follow
// one per cycle while the result side keeps up. A real test first reads
// the closing vertex and then vertex 0, walks the edges in order, then
// settles the last edge and loads the result register; the next input
// transfer waits until the sequencer is idle and the result is taken.
// Each edge uses the single 25x25 signed multiplier twice, forming
// (px - xi) * dy and then (xj - xi) * (py - yi); the compare of one edge
// overlaps the first product of the next. Vertex reads come from a
// registered simple dual-port memory. Item ready drops while a
// test runs and while an undelivered result blocks the result register.
// Appends past capacity are dropped with status full; the vertex store has
// no reset and needs none, since only written entries are read.

module point_in_polygon_test
	import pip_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    item_valid,
	output logic         item_ready,
	input  wire item_t   item,
	output logic         res_valid,
	input  wire logic    res_ready,
	output result_t      res
);

	state_t            state_q, state_d;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  cnt_m1;
	logic [ADDR_W-1:0] last_idx;
	logic [ADDR_W-1:0] idx_q;
	logic              last_edge;

	logic              accept;
	logic              test_go;
	logic              full;

	coord_t            px_q, py_q, xj_q, yj_q;
	vertex_t           vi;
	vertex_t           wr_v;
	vs_ctrl_t          vs_ctrl;

	logic              mul_en;
	diff_t             mul_a, mul_b;
	prod_t             prod;
	prod_t             lhs_q;

	logic              pend_q;
	logic              straddle_q;
	logic              dyneg_q;
	logic              inside_q;
	logic              toggle;

	logic              res_valid_q;
	result_t           res_q;

	// ---------------------------------------------------------------------
	// Handshake and item decode
	// ---------------------------------------------------------------------
	assign item_ready = (state_q == S_IDLE) && (!res_valid_q || res_ready);
	assign accept     = item_valid && item_ready;
	assign full       = count_q >= CNT_W'(MAX_VERTICES);
	assign test_go    = accept && (item.op == OP_TEST) && (count_q >= CNT_W'(3));

	// Closing edge starts from the last stored vertex.
	assign cnt_m1    = count_q - CNT_W'(1);
	assign last_idx  = cnt_m1[ADDR_W-1:0];
	assign last_edge = (idx_q == last_idx);

	// ---------------------------------------------------------------------
	// Vertex store and shared multiplier
	// ---------------------------------------------------------------------
	assign wr_v.x = item.coord_x;
	assign wr_v.y = item.coord_y;

	pip_vstore u_vstore (
		.clk     (clk),
		.ctrl    (vs_ctrl),
		.wr_data (wr_v),
		.rd_q    (vi)
	);

	pip_mul u_mul (
		.clk    (clk),
		.en     (mul_en),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod)
	);

	// Edge (i, j) toggles when it straddles the point's y and the point lies
	// strictly left of the crossing; flip the compare when dy is negative.
	// lhs_q holds (px - xi) * dy, prod holds (xj - xi) * (py - yi).
	assign toggle = pend_q && straddle_q && (dyneg_q ? (lhs_q > prod) : (lhs_q < prod));

	// ---------------------------------------------------------------------
	// Sequencer: next state
	// ---------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (test_go) begin
					state_d = S_FETCHJ;
				end
			end
			S_FETCHJ: begin
				state_d = S_EDGE_A;
			end
			S_EDGE_A: begin
				state_d = S_EDGE_B;
			end
			S_EDGE_B: begin
				state_d = last_edge ? S_FINISH : S_EDGE_A;
			end
			S_FINISH: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// ---------------------------------------------------------------------
	// Sequencer: control outputs
	// ---------------------------------------------------------------------
	always_comb begin
		vs_ctrl.wr_en   = accept && (item.op == OP_APPEND) && !full;
		vs_ctrl.wr_addr = count_q[ADDR_W-1:0];
		vs_ctrl.rd_en   = 1'b0;
		vs_ctrl.rd_addr = '0;
		mul_en          = 1'b0;
		// first pass of an edge: (px - xi) * (yj - yi)
		mul_a           = diff_t'(px_q) - diff_t'(vi.x);
		mul_b           = diff_t'(yj_q) - diff_t'(vi.y);
		case (state_q)
			S_IDLE: begin
				vs_ctrl.rd_en   = test_go;
				vs_ctrl.rd_addr = last_idx;
			end
			S_FETCHJ: begin
				vs_ctrl.rd_en   = 1'b1;
				vs_ctrl.rd_addr = '0;
			end
			S_EDGE_A: begin
				mul_en = 1'b1;
			end
			S_EDGE_B: begin
				// second pass: (xj - xi) * (py - yi); prefetch the next vertex
				mul_en          = 1'b1;
				mul_a           = diff_t'(xj_q) - diff_t'(vi.x);
				mul_b           = diff_t'(py_q) - diff_t'(vi.y);
				vs_ctrl.rd_en   = !last_edge;
				vs_ctrl.rd_addr = idx_q + ADDR_W'(1);
			end
			S_FINISH: begin
				mul_en = 1'b0;
			end
			default: begin
				mul_en = 1'b0;
			end
		endcase
	end

	// ---------------------------------------------------------------------
	// Control registers
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			pend_q      <= 1'b0;
			inside_q    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			// polygon bookkeeping
			if (accept && (item.op == OP_CLEAR)) begin
				count_q <= '0;
			end else if (vs_ctrl.wr_en) begin
				count_q <= count_q + CNT_W'(1);
			end

			case (state_q)
				S_IDLE: begin
					inside_q <= 1'b0;
					pend_q   <= 1'b0;
				end
				S_FETCHJ: begin
					idx_q <= '0;
				end
				S_EDGE_A: begin
					// settle the previous edge
					inside_q <= inside_q ^ toggle;
					pend_q   <= 1'b0;
				end
				S_EDGE_B: begin
					pend_q <= 1'b1;
					idx_q  <= idx_q + ADDR_W'(1);
				end
				default: begin
					pend_q <= pend_q;
				end
			endcase

			// result register: load on an immediate item or at test end,
			// drop once the downstream side takes it
			if ((accept && !test_go) || (state_q == S_FINISH)) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------------
	// Payload registers
	// ---------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (test_go) begin
			px_q <= item.coord_x;
			py_q <= item.coord_y;
		end

		if (state_q == S_FETCHJ) begin
			xj_q <= vi.x;
			yj_q <= vi.y;
		end

		if (state_q == S_EDGE_B) begin
			lhs_q      <= prod;
			straddle_q <= (vi.y > py_q) != (yj_q > py_q);
			dyneg_q    <= yj_q < vi.y;
			// vertex i becomes vertex j of the next edge
			xj_q       <= vi.x;
			yj_q       <= vi.y;
		end

		if (accept && !test_go) begin
			res_q.inside_res <= 1'b0;
			if ((item.op == OP_APPEND) && full) begin
				res_q.status <= ST_FULL;
			end else if (item.op == OP_TEST) begin
				res_q.status <= ST_FEW;
			end else begin
				res_q.status <= ST_OK;
			end
		end else if (state_q == S_FINISH) begin
			res_q.inside_res <= inside_q ^ toggle;
			res_q.status     <= ST_OK;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

`ifndef ASSERT_OFF
	// the result register is always free when a test finishes
	a_finish_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FINISH) |-> !res_valid_q)
		else $error("test finished with result register still occupied");

	// the vertex count never exceeds capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_VERTICES))
		else $error("vertex count above capacity");

	// an edge walk only runs on a polygon of three or more vertices
	a_walk_min: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EDGE_A) |-> (count_q >= CNT_W'(3)))
		else $error("edge walk on degenerate polygon");

	// the polygon does not change while a test runs
	a_count_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |=> $stable(count_q))
		else $error("vertex count changed during a test");

	// a result appears only after an input transfer or at the end of a test
	a_res_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> ($past(accept) || $past(state_q == S_FINISH)))
		else $error("result raised without a source");
`endif

endmodule

`default_nettype wire
